// ----- sv/pbbs_pkg.sv -----
// Shared types, widths and codes of the priority byte budget shaper.
package pbbs_pkg;

    localparam int FIELD_QUEUES = 4;
    localparam int CMD_W        = 2;
    localparam int LEN_W        = 10;
    localparam int PRIO_W       = 7;
    localparam int LIMIT_W      = 16;
    localparam int BUDGET_W     = 17;
    localparam int QIDX_W       = 2;
    localparam int TICK_W       = 2;
    localparam int CHARGE_W     = LEN_W + 1;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int QDEPTH       = 2;

    // stream payload widths; the tdata widths are whole bytes
    localparam int IN_TDATA_W   = 48;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 24;

    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SHAPING_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOD_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_Q0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_Q1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_Q2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_Q3    = 3'd5;

    localparam logic [LIMIT_W-1:0]  LIMIT_RESET    = 16'd9000;
    localparam logic [PRIO_W-1:0]   NO_SERVE_PRIO  = 7'd100;
    localparam logic [BUDGET_W-1:0] BUDGET_MAX     = 17'd131071;
    localparam logic [BUDGET_W-1:0] DECAY_STEP     = 17'd75;
    localparam logic [BUDGET_W:0]   HIGH_MARGIN    = 18'd100;
    localparam logic [BUDGET_W:0]   LEN_MARGIN     = 18'd150;
    localparam logic [TICK_W-1:0]   SEND_WAIT      = 2'd2;

    typedef logic [PRIO_W-1:0] prio_t;

    typedef struct packed {
        logic                         shaping_enable;
        logic [LIMIT_W-1:0]           flood_limit;
        prio_t [FIELD_QUEUES-1:0]     priority_q;
    } cfg_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic              found;
        logic [QIDX_W-1:0] qidx;
        logic [LEN_W-1:0]  head_len;
        logic              penalized;
        logic              all_empty;
    } work_t;

endpackage

// ----- sv/priority_byte_budget_shaper_unit.sv -----
// Top level of the priority byte budget shaper.
// An accepted beat is written into the queue; the back end then registers its result on m_*.
// Throughput: one beat per cycle unless output stalls fill the queue; the back end updates the budget on each pop.
// A two-entry queue between classify and update absorbs output stalls.
// Reset (rst_n low, asynchronous): budget 0, wait elapsed, decay stopped,
// queue empty, registers to their defaults; no beats are pending.
module priority_byte_budget_shaper_unit
#(
    parameter int NUM_QUEUES = 4
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    // fields from bit 0: nonempty_mask[3:0], penalized_mask[7:4],
    // head_len_q0[17:8], head_len_q1[27:18], head_len_q2[37:28], head_len_q3[47:38]
    input  logic [pbbs_pkg::IN_TDATA_W-1:0]    s_tdata,
    // fields from bit 0: command[1:0]
    input  logic [pbbs_pkg::IN_TUSER_W-1:0]    s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // fields from bit 0: granted[0], queue_index[2:1], budget_level[19:3],
    // decay_active[20], zero pad [23:21]
    output logic [pbbs_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pbbs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pbbs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    pbbs_pkg::cfg_t  cfg;
    pbbs_pkg::work_t front_item;
    pbbs_pkg::work_t back_item;
    logic            queue_full;
    logic            back_valid;
    logic            back_pop;

    assign s_tready = !queue_full;

    pbbs_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pbbs_front #(.NUM_QUEUES(NUM_QUEUES)) u_front
    (
        .tuser (s_tuser),
        .tdata (s_tdata),
        .cfg   (cfg),
        .work  (front_item)
    );

    pbbs_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (s_tvalid && !queue_full),
        .wr_item  (front_item),
        .full     (queue_full),
        .rd_en    (back_pop),
        .rd_valid (back_valid),
        .rd_item  (back_item)
    );

    pbbs_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (back_valid),
        .item       (back_item),
        .pop        (back_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ----- sv/pbbs_cfg.sv -----
// Configuration register file of the shaper.
module pbbs_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pbbs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pbbs_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pbbs_pkg::cfg_t                    cfg
);

    pbbs_pkg::cfg_t cfg_reg;
    pbbs_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                pbbs_pkg::REG_SHAPING_ENABLE: cfg_next.shaping_enable = cfg_data[0];
                pbbs_pkg::REG_FLOOD_LIMIT:    cfg_next.flood_limit = cfg_data[pbbs_pkg::LIMIT_W-1:0];
                pbbs_pkg::REG_PRIORITY_Q0:    cfg_next.priority_q[0] = cfg_data[pbbs_pkg::PRIO_W-1:0];
                pbbs_pkg::REG_PRIORITY_Q1:    cfg_next.priority_q[1] = cfg_data[pbbs_pkg::PRIO_W-1:0];
                pbbs_pkg::REG_PRIORITY_Q2:    cfg_next.priority_q[2] = cfg_data[pbbs_pkg::PRIO_W-1:0];
                pbbs_pkg::REG_PRIORITY_Q3:    cfg_next.priority_q[3] = cfg_data[pbbs_pkg::PRIO_W-1:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shaping_enable <= 1'b1;
            cfg_reg.flood_limit    <= pbbs_pkg::LIMIT_RESET;
            for (int i = 0; i < pbbs_pkg::FIELD_QUEUES; i++)
            begin
                cfg_reg.priority_q[i] <= pbbs_pkg::NO_SERVE_PRIO;
            end
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- sv/pbbs_front.sv -----
// Front end: unpacks an input beat and picks the eligible queue.
module pbbs_front
#(
    parameter int NUM_QUEUES = 4
)
(
    input  logic [pbbs_pkg::IN_TUSER_W-1:0]  tuser,
    input  logic [pbbs_pkg::IN_TDATA_W-1:0]  tdata,
    input  pbbs_pkg::cfg_t                   cfg,
    output pbbs_pkg::work_t                  work
);

    localparam int NQ = (NUM_QUEUES < pbbs_pkg::FIELD_QUEUES) ?
                        NUM_QUEUES : pbbs_pkg::FIELD_QUEUES;
    localparam int LEN_BASE = 2 * pbbs_pkg::FIELD_QUEUES;

    logic [pbbs_pkg::FIELD_QUEUES-1:0] present_mask;
    logic [pbbs_pkg::FIELD_QUEUES-1:0] nonempty;
    logic [pbbs_pkg::FIELD_QUEUES-1:0] penal;
    logic [pbbs_pkg::LEN_W-1:0]        lens [pbbs_pkg::FIELD_QUEUES];
    pbbs_pkg::prio_t                   best;
    logic                              found;
    logic [pbbs_pkg::QIDX_W-1:0]       qidx;

    always_comb
    begin
        for (int i = 0; i < pbbs_pkg::FIELD_QUEUES; i++)
        begin
            present_mask[i] = (i < NQ);
            lens[i] = tdata[LEN_BASE + i*pbbs_pkg::LEN_W +: pbbs_pkg::LEN_W];
        end
        nonempty = tdata[pbbs_pkg::FIELD_QUEUES-1:0] & present_mask;
        penal    = tdata[2*pbbs_pkg::FIELD_QUEUES-1:pbbs_pkg::FIELD_QUEUES];
    end

    // strict less-than keeps the lowest index on a tie
    always_comb
    begin
        best  = pbbs_pkg::NO_SERVE_PRIO;
        found = 1'b0;
        qidx  = '0;
        for (int i = 0; i < NQ; i++)
        begin
            if (nonempty[i] && (cfg.priority_q[i] < best))
            begin
                best  = cfg.priority_q[i];
                qidx  = pbbs_pkg::QIDX_W'(i);
                found = 1'b1;
            end
        end
    end

    always_comb
    begin
        work.command   = tuser[pbbs_pkg::CMD_W-1:0];
        work.found     = found;
        work.qidx      = qidx;
        work.head_len  = lens[qidx];
        work.penalized = penal[qidx];
        work.all_empty = (nonempty == '0);
    end

endmodule

// ----- sv/pbbs_queue.sv -----
// Short queue of classified items between front and back.
module pbbs_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  pbbs_pkg::work_t wr_item,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output pbbs_pkg::work_t rd_item
);

    localparam int PTR_W = (pbbs_pkg::QDEPTH > 1) ? $clog2(pbbs_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(pbbs_pkg::QDEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(pbbs_pkg::QDEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(pbbs_pkg::QDEPTH - 1);

    pbbs_pkg::work_t   entry_reg [pbbs_pkg::QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full     = (count_reg == DEPTH_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ----- sv/pbbs_back.sv -----
// Back end: grant checks, budget charge and decay, output register.
module pbbs_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  pbbs_pkg::cfg_t                   cfg,
    input  logic                             item_valid,
    input  pbbs_pkg::work_t                  item,
    output logic                             pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pbbs_pkg::OUT_TDATA_W-1:0] m_tdata
);

    localparam int BW = pbbs_pkg::BUDGET_W;

    logic [BW-1:0]                    budget_reg;
    logic [BW-1:0]                    budget_next;
    logic [pbbs_pkg::TICK_W-1:0]      ticks_reg;
    logic [pbbs_pkg::TICK_W-1:0]      ticks_next;
    logic                             decay_reg;
    logic                             decay_next;
    logic                             out_valid_reg;
    logic [pbbs_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic [pbbs_pkg::OUT_TDATA_W-1:0] out_data_next;

    logic [BW:0]                      lim_ext;
    logic                             too_high;
    logic                             len_over;
    logic                             over_quarter;
    logic                             is_req;
    logic                             ok;
    logic [pbbs_pkg::CHARGE_W-1:0]    charge;
    logic [BW:0]                      charged_sum;
    logic [BW-1:0]                    charged;
    logic [BW-1:0]                    decayed;
    logic [pbbs_pkg::QIDX_W-1:0]      qidx_out;

    assign pop      = item_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        lim_ext      = {{(BW + 1 - pbbs_pkg::LIMIT_W){1'b0}}, cfg.flood_limit};
        too_high     = ({1'b0, budget_reg} + pbbs_pkg::HIGH_MARGIN) > lim_ext;
        len_over     = ({1'b0, budget_reg} + (BW + 1)'(item.head_len)
                        + pbbs_pkg::LEN_MARGIN) > lim_ext;
        over_quarter = budget_reg > BW'(cfg.flood_limit >> 2);
        is_req       = (item.command == pbbs_pkg::CMD_PEEK)
                       || (item.command == pbbs_pkg::CMD_DEQUEUE);
        ok = is_req && (ticks_reg >= pbbs_pkg::SEND_WAIT) && item.found
             && !(cfg.shaping_enable && too_high)
             && !(cfg.shaping_enable && len_over && over_quarter);

        charge      = item.penalized ? {item.head_len, 1'b0} : {1'b0, item.head_len};
        charged_sum = {1'b0, budget_reg} + (BW + 1)'(charge);
        charged     = charged_sum[BW] ? pbbs_pkg::BUDGET_MAX : charged_sum[BW-1:0];
        decayed     = (budget_reg < pbbs_pkg::DECAY_STEP) ? '0
                      : budget_reg - pbbs_pkg::DECAY_STEP;
    end

    always_comb
    begin
        budget_next = budget_reg;
        ticks_next  = ticks_reg;
        decay_next  = decay_reg;
        case (item.command)
            pbbs_pkg::CMD_TICK:
            begin
                if (ticks_reg < pbbs_pkg::SEND_WAIT)
                begin
                    ticks_next = ticks_reg + 1'b1;
                end
                if (decay_reg)
                begin
                    budget_next = decayed;
                    if (item.all_empty && (decayed == '0))
                    begin
                        decay_next = 1'b0;
                    end
                end
            end
            pbbs_pkg::CMD_DEQUEUE:
            begin
                if (ok)
                begin
                    ticks_next = '0;
                    if (cfg.shaping_enable)
                    begin
                        budget_next = charged;
                        decay_next  = 1'b1;
                    end
                end
            end
            default:
            begin
                budget_next = budget_reg;
            end
        endcase
        qidx_out      = ok ? item.qidx : '0;
        out_data_next = {{(pbbs_pkg::OUT_TDATA_W - BW - 4){1'b0}},
                         decay_next, budget_next, qidx_out, ok};
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg    <= '0;
            ticks_reg     <= pbbs_pkg::SEND_WAIT;
            decay_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                budget_reg <= budget_next;
                ticks_reg  <= ticks_next;
                decay_reg  <= decay_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- sv/pbbs_checker.sv -----
// Port-level checks of the shaper and their bind to the top level.
module pbbs_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [pbbs_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // output beat held while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    // a refused request reports queue 0
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[2:1] == 2'd0))
        else $error("queue index set without grant");

    // budget only grows by a charge, which starts decay; decay stops only at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[20] |-> (m_tdata[19:3] == 17'd0))
        else $error("budget nonzero while decay stopped");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[23:21] == 3'd0))
        else $error("pad bits of output beat not zero");

endmodule

bind priority_byte_budget_shaper_unit pbbs_checker u_pbbs_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- tb/tb_priority_byte_budget_shaper_unit.sv -----
// Self-checking testbench for the priority byte budget shaper: directed and random traffic.
module tb_priority_byte_budget_shaper_unit;

    import pbbs_pkg::*;

    localparam int QUEUES      = 4;
    localparam int CYCLE_LIMIT = 100000;
    localparam int RAND_PHASES = 4;
    localparam int PHASE_ITEMS = 58;

    // command code the block has no use for
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // s_tdata layout, lowest bits last
    typedef struct packed {
        logic [FIELD_QUEUES-1:0][LEN_W-1:0] head_len;
        logic [FIELD_QUEUES-1:0]            penalized;
        logic [FIELD_QUEUES-1:0]            nonempty;
    } queue_view_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        queue_view_t      qv;
    } shaper_item_t;

    // m_tdata layout, granted in bit 0
    typedef struct packed {
        logic                decay_active;
        logic [BUDGET_W-1:0] budget_level;
        logic [QIDX_W-1:0]   queue_index;
        logic                granted;
    } shaper_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [IN_TUSER_W-1:0]  s_tuser   = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // shadow of the shaper state and its registers
    cfg_t                   shaper_cfg;
    logic [BUDGET_W-1:0]    bud_level;
    logic [TICK_W-1:0]      since_send;
    logic                   decay_on;

    shaper_result_t         grant_expect_q[$];
    shaper_result_t         got_result;
    shaper_result_t         want_result;
    int                     fail_count  = 0;
    int                     cycle_count = 0;
    int                     tx_idle_pct = 0;
    int                     rx_idle_pct = 0;
    int                     rx_hold     = 0;

    priority_byte_budget_shaper_unit
    #(
        .NUM_QUEUES (QUEUES)
    )
    i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic void reset_shadow();
        shaper_cfg.shaping_enable = 1'b1;
        shaper_cfg.flood_limit    = LIMIT_RESET;
        for (int q = 0; q < FIELD_QUEUES; q++)
            shaper_cfg.priority_q[q] = NO_SERVE_PRIO;
        bud_level  = '0;
        since_send = SEND_WAIT;
        decay_on   = 1'b0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SHAPING_ENABLE: shaper_cfg.shaping_enable = data[0];
            REG_FLOOD_LIMIT:    shaper_cfg.flood_limit    = data[LIMIT_W-1:0];
            REG_PRIORITY_Q0:    shaper_cfg.priority_q[0]  = data[PRIO_W-1:0];
            REG_PRIORITY_Q1:    shaper_cfg.priority_q[1]  = data[PRIO_W-1:0];
            REG_PRIORITY_Q2:    shaper_cfg.priority_q[2]  = data[PRIO_W-1:0];
            REG_PRIORITY_Q3:    shaper_cfg.priority_q[3]  = data[PRIO_W-1:0];
            default: ;
        endcase
    endfunction

    // advances the shadow state by one beat and returns the grant it produces
    function automatic shaper_result_t predict_grant(input shaper_item_t it);
        shaper_result_t      res;
        int                  lim;
        int                  bud;
        int                  best;
        int                  q;
        logic                ok;
        logic                found;
        logic [QIDX_W-1:0]   pick;
        logic [CHARGE_W-1:0] charge;
        logic [BUDGET_W:0]   total;
        res   = '0;
        ok    = 1'b1;
        found = 1'b0;
        pick  = '0;
        best  = int'(NO_SERVE_PRIO);
        lim   = int'(shaper_cfg.flood_limit);
        bud   = int'(bud_level);
        if (it.command == CMD_TICK)
        begin
            if (since_send < SEND_WAIT)
                since_send = since_send + 1'b1;
            if (decay_on)
            begin
                bud_level = bud_level - ((bud_level < DECAY_STEP) ? bud_level : DECAY_STEP);
                if (it.qv.nonempty == '0 && bud_level == '0)
                    decay_on = 1'b0;
            end
        end
        else if (it.command == CMD_PEEK || it.command == CMD_DEQUEUE)
        begin
            if (shaper_cfg.shaping_enable && bud > lim - int'(HIGH_MARGIN))
                ok = 1'b0;
            if (since_send < SEND_WAIT)
                ok = 1'b0;
            if (ok)
            begin
                for (q = 0; q < QUEUES; q++)
                begin
                    // strict compare keeps the lowest index on a tie
                    if (it.qv.nonempty[q] && int'(shaper_cfg.priority_q[q]) < best)
                    begin
                        best  = int'(shaper_cfg.priority_q[q]);
                        pick  = q[QIDX_W-1:0];
                        found = 1'b1;
                    end
                end
                ok = found;
            end
            if (ok && shaper_cfg.shaping_enable &&
                int'(it.qv.head_len[pick]) + bud > lim - int'(LEN_MARGIN) &&
                bud > int'(shaper_cfg.flood_limit >> 2))
                ok = 1'b0;
            if (ok && it.command == CMD_DEQUEUE)
            begin
                if (shaper_cfg.shaping_enable)
                begin
                    charge = it.qv.penalized[pick] ? {it.qv.head_len[pick], 1'b0}
                                                   : {1'b0, it.qv.head_len[pick]};
                    total  = {1'b0, bud_level} + charge;
                    bud_level = (total > BUDGET_MAX) ? BUDGET_MAX : total[BUDGET_W-1:0];
                    decay_on  = 1'b1;
                end
                since_send = '0;
            end
            res.granted     = ok;
            res.queue_index = ok ? pick : '0;
        end
        res.budget_level = bud_level;
        res.decay_active = decay_on;
        return res;
    endfunction

    function automatic void report_mismatch(input string field, input int unsigned exp_val,
                                            input int unsigned act_val);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
        fail_count++;
    endfunction

    // all bus sampling happens at the falling edge, where inputs and outputs are settled
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                apply_reg(cfg_index, cfg_data);
            if (m_tvalid && m_tready)
            begin
                got_result = m_tdata[$bits(shaper_result_t)-1:0];
                if (grant_expect_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %h", $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want_result = grant_expect_q.pop_front();
                    if (got_result.granted !== want_result.granted)
                        report_mismatch("granted", want_result.granted, got_result.granted);
                    if (got_result.queue_index !== want_result.queue_index)
                        report_mismatch("queue_index", want_result.queue_index,
                                        got_result.queue_index);
                    if (got_result.budget_level !== want_result.budget_level)
                        report_mismatch("budget_level", want_result.budget_level,
                                        got_result.budget_level);
                    if (got_result.decay_active !== want_result.decay_active)
                        report_mismatch("decay_active", want_result.decay_active,
                                        got_result.decay_active);
                end
            end
            if (s_tvalid && s_tready)
                grant_expect_q.push_back(predict_grant({s_tuser, s_tdata}));
        end
    end

    always @(negedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, grant_expect_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // called right after a rising edge; returns at the edge that took the beat
    task automatic send_item(input shaper_item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it.qv;
        s_tuser  <= it.command;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (grant_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic shaper_item_t make_item(input logic [CMD_W-1:0] cmd,
                                               input logic [FIELD_QUEUES-1:0] ne,
                                               input logic [FIELD_QUEUES-1:0] pen,
                                               input logic [LEN_W-1:0] len);
        shaper_item_t it;
        it.command      = cmd;
        it.qv.nonempty  = ne;
        it.qv.penalized = pen;
        it.qv.head_len  = {FIELD_QUEUES{len}};
        return it;
    endfunction

    function automatic shaper_item_t random_item(input logic [CMD_W-1:0] cmd);
        shaper_item_t it;
        int           pick;
        it.command      = cmd;
        it.qv.nonempty  = ($urandom_range(9) == 0) ? '0 : FIELD_QUEUES'($urandom_range(15));
        it.qv.penalized = FIELD_QUEUES'($urandom_range(15));
        for (int q = 0; q < FIELD_QUEUES; q++)
        begin
            pick = $urandom_range(9);
            it.qv.head_len[q] = (pick == 0) ? LEN_W'(0) :
                                (pick == 1) ? LEN_W'(512) : LEN_W'($urandom_range(512));
        end
        return it;
    endfunction

    task automatic set_random_config();
        logic [CFG_DATA_W-1:0] limit;
        case ($urandom_range(5))
            0:       limit = 16'd256;
            1:       limit = 16'd65535;
            2:       limit = 16'd1000;
            3:       limit = LIMIT_RESET;
            default: limit = CFG_DATA_W'($urandom_range(256, 65535));
        endcase
        write_reg(REG_SHAPING_ENABLE, ($urandom_range(3) != 0) ? 16'd1 : 16'd0);
        write_reg(REG_FLOOD_LIMIT, limit);
        write_reg(REG_PRIORITY_Q0, CFG_DATA_W'(($urandom_range(3) == 0) ?
                                   $urandom_range(100, 127) : $urandom_range(99)));
        write_reg(REG_PRIORITY_Q1, CFG_DATA_W'(($urandom_range(3) == 0) ?
                                   $urandom_range(100, 127) : $urandom_range(99)));
        write_reg(REG_PRIORITY_Q2, CFG_DATA_W'(($urandom_range(3) == 0) ?
                                   $urandom_range(100, 127) : $urandom_range(99)));
        write_reg(REG_PRIORITY_Q3, CFG_DATA_W'(($urandom_range(3) == 0) ?
                                   $urandom_range(100, 127) : $urandom_range(99)));
    endtask

    // mostly tick runs, which may let the wait expire, followed by a request, plus noise
    task automatic send_random_traffic(input int count);
        int sent;
        int roll;
        sent = 0;
        while (sent < count)
        begin
            roll = $urandom_range(99);
            if (roll < 65)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    send_item(random_item(CMD_TICK));
                    sent++;
                end
                send_item(random_item(($urandom_range(3) == 0) ? CMD_PEEK : CMD_DEQUEUE));
                sent++;
            end
            else if (roll < 72)
            begin
                // empty queues let the decay timer run down and stop
                repeat ($urandom_range(4, 16))
                begin
                    send_item(make_item(CMD_TICK, '0, FIELD_QUEUES'($urandom_range(15)),
                                        LEN_W'($urandom_range(512))));
                    sent++;
                end
            end
            else if (roll < 75)
            begin
                send_item(random_item(CMD_UNUSED));
            end
            else
            begin
                send_item(random_item(CMD_W'($urandom_range(2))));
                sent++;
            end
        end
    endtask

    task automatic test_reset_defaults();
        // every priority starts at the no-serve level
        send_item(make_item(CMD_PEEK, 4'hf, 4'h0, 10'd0));
        send_item(make_item(CMD_TICK, 4'hf, 4'h0, 10'd0));
    endtask

    task automatic test_priority_select();
        write_reg(REG_SHAPING_ENABLE, 16'd1);
        write_reg(REG_FLOOD_LIMIT, LIMIT_RESET);
        write_reg(REG_PRIORITY_Q0, 16'd40);
        write_reg(REG_PRIORITY_Q1, 16'd10);
        write_reg(REG_PRIORITY_Q2, 16'd10);
        write_reg(REG_PRIORITY_Q3, 16'd127);
        send_item(make_item(CMD_PEEK, 4'hf, 4'h0, 10'd512));    // tie, lower index
        send_item(make_item(CMD_PEEK, 4'h9, 4'h0, 10'd512));
        send_item(make_item(CMD_PEEK, 4'h8, 4'h0, 10'd512));    // only unserved queue
        send_item(make_item(CMD_DEQUEUE, 4'hf, 4'hf, 10'd512)); // doubled charge
        send_item(make_item(CMD_PEEK, 4'hf, 4'h0, 10'd0));      // wait not elapsed
        send_item(make_item(CMD_TICK, 4'hf, 4'h0, 10'd0));
        send_item(make_item(CMD_TICK, 4'hf, 4'h0, 10'd0));
        send_item(make_item(CMD_DEQUEUE, 4'h2, 4'h0, 10'd0));
    endtask

    task automatic test_budget_limits();
        write_reg(REG_PRIORITY_Q3, 16'd0);
        write_reg(REG_FLOOD_LIMIT, 16'd1000);
        send_item(make_item(CMD_TICK, 4'hf, 4'h0, 10'd0));
        send_item(make_item(CMD_TICK, 4'hf, 4'h0, 10'd0));
        send_item(make_item(CMD_PEEK, 4'hf, 4'h0, 10'd512));    // head too long
        send_item(make_item(CMD_DEQUEUE, 4'h8, 4'h8, 10'd100));
        // limit below range: thresholds go negative
        write_reg(REG_FLOOD_LIMIT, 16'd0);
        send_item(make_item(CMD_PEEK, 4'hf, 4'h0, 10'd0));
        write_reg(REG_FLOOD_LIMIT, 16'd65535);
        send_item(make_item(CMD_TICK, 4'hf, 4'h0, 10'd0));
        send_item(make_item(CMD_TICK, 4'hf, 4'h0, 10'd0));
        send_item(make_item(CMD_DEQUEUE, 4'hf, 4'hf, 10'd512));
        write_reg(REG_FLOOD_LIMIT, 16'd256);
        send_item(make_item(CMD_PEEK, 4'hf, 4'h0, 10'd0));
    endtask

    task automatic test_shaping_off();
        write_reg(REG_SHAPING_ENABLE, 16'd0);
        send_item(make_item(CMD_TICK, 4'h0, 4'h0, 10'd0));
        send_item(make_item(CMD_TICK, 4'h0, 4'h0, 10'd0));
        send_item(make_item(CMD_DEQUEUE, 4'hf, 4'hf, 10'd512)); // no charge
        send_item(make_item(CMD_PEEK, 4'hf, 4'h0, 10'd512));    // wait still applies
        send_item(make_item(CMD_TICK, 4'h0, 4'h0, 10'd0));
    endtask

    task automatic test_unused_command();
        send_item(make_item(CMD_UNUSED, 4'hf, 4'hf, 10'd512));
        send_item(make_item(CMD_UNUSED, 4'h0, 4'h0, 10'd0));
    endtask

    task automatic test_backpressure();
        drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        @(negedge clk);
        rx_hold = 120;
        @(posedge clk);
        repeat (12)
            send_item(random_item(CMD_W'($urandom_range(2))));
        drain();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            set_random_config();
            send_random_traffic(PHASE_ITEMS);
        end
    endtask

    initial
    begin
        reset_shadow();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_priority_select();
        test_budget_limits();
        test_shaping_off();
        test_unused_command();
        test_backpressure();
        test_random_traffic(22, 55);
        test_random_traffic(55, 22);
        test_random_traffic(0, 0);
        drain();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
